// File: rtl/wmmp_pkg.sv
`default_nettype none

package wmmp_pkg;

  localparam int unsigned MaxLevels    = 12;
  localparam int unsigned FrameSamples = 16;
  localparam int unsigned CntW         = $clog2(FrameSamples);
  localparam int unsigned LvlW         = 4;
  localparam int unsigned IdxW         = 20;

  // Register indexes on the configuration port.
  localparam logic RegLevelCount = 1'b0;
  localparam logic RegFrameLimit = 1'b1;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               start_clip;
  } in_word_t;

  typedef struct packed {
    logic [LvlW-1:0]   level;
    logic [IdxW-1:0]   frame_index;
    logic signed [7:0] min_value;
    logic [6:0]        max_value;
    logic              last_of_run;
  } out_word_t;

  // Controller to datapath.
  typedef struct packed {
    logic take;  // accept the input word
    logic step;  // the presented word is taken; move up the cascade
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic frame_done;  // the input word would complete a level-0 frame
    logic last;        // the presented word is the last of its run
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

endpackage

`default_nettype wire

// File: rtl/wmmp_ctrl.sv
`default_nettype none

module wmmp_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  input  wmmp_pkg::status_t  status_i,
  output wmmp_pkg::cmd_t     cmd_o
);

  wmmp_pkg::state_e state_q, state_d;

  always_comb begin
    cmd_o.take  = (state_q == wmmp_pkg::ST_IDLE) && in_valid_i;
    cmd_o.step  = (state_q == wmmp_pkg::ST_EMIT) && !out_stall_i;
    in_stall_o  = (state_q != wmmp_pkg::ST_IDLE);
    out_valid_o = (state_q == wmmp_pkg::ST_EMIT);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wmmp_pkg::ST_IDLE: begin
        if (cmd_o.take && status_i.frame_done) state_d = wmmp_pkg::ST_EMIT;
      end
      wmmp_pkg::ST_EMIT: begin
        if (cmd_o.step && status_i.last) state_d = wmmp_pkg::ST_IDLE;
      end
      default: state_d = wmmp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wmmp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/wmmp_datapath.sv
`default_nettype none

module wmmp_datapath (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wmmp_pkg::cmd_t                      cmd_i,
  input  wmmp_pkg::in_word_t                  in_word_i,
  input  wire  [wmmp_pkg::LvlW-1:0]           level_count_i,
  input  wire  [wmmp_pkg::IdxW-1:0]           frame_limit_i,
  output wmmp_pkg::status_t                   status_o,
  output wmmp_pkg::out_word_t                 out_word_o
);

  localparam int unsigned NL = wmmp_pkg::MaxLevels;
  localparam int unsigned LW = wmmp_pkg::LvlW;
  localparam int unsigned IW = wmmp_pkg::IdxW;
  localparam int unsigned CW = wmmp_pkg::CntW;

  // Q1.15 times 127, truncated toward zero.
  function automatic logic signed [7:0] scale_q15(input logic signed [15:0] s);
    logic [16:0] mag;
    logic [23:0] prod;
    logic [7:0]  r;
    mag  = s[15] ? (17'd0 - {s[15], s}) : {1'b0, s};
    prod = {7'd0, mag} * 24'd127;
    r    = {1'b0, prod[21:15]};
    return s[15] ? $signed(8'd0 - r) : $signed(r);
  endfunction

  logic [CW-1:0]        cnt_q;
  logic signed [15:0]   lo_q, hi_q;
  logic [IW-1:0]        fin_q;
  logic [NL-1:0]        half_q;
  logic signed [7:0]    held_lo_q [NL];
  logic [6:0]           held_hi_q [NL];
  logic [IW-1:0]        lvl_cnt_q [NL];
  logic [LW-1:0]        lv_q;
  logic signed [7:0]    carry_lo_q;
  logic [6:0]           carry_hi_q;
  wmmp_pkg::out_word_t  out_q;

  logic [CW-1:0]        cnt_e;
  logic signed [15:0]   lo_e, hi_e, lo_n, hi_n;
  logic [IW-1:0]        fin_e;
  logic                 blocked, completes;
  logic [LW-1:0]        levels, lv_nx;
  logic                 half_here, half_next;
  logic signed [7:0]    scaled_lo, scaled_hi, merge_lo;
  logic [6:0]           merge_hi;

  always_comb begin
    // A start of clip clears everything before the sample is looked at.
    cnt_e   = in_word_i.start_clip ? '0 : cnt_q;
    lo_e    = in_word_i.start_clip ? '0 : lo_q;
    hi_e    = in_word_i.start_clip ? '0 : hi_q;
    fin_e   = in_word_i.start_clip ? '0 : fin_q;
    blocked = (fin_e >= frame_limit_i);
    lo_n    = (in_word_i.sample < lo_e) ? in_word_i.sample : lo_e;
    hi_n    = (in_word_i.sample > hi_e) ? in_word_i.sample : hi_e;
    completes = !blocked && (cnt_e == CW'(wmmp_pkg::FrameSamples - 1));
    scaled_lo = scale_q15(lo_n);
    scaled_hi = scale_q15(hi_n);

    levels = (level_count_i > LW'(NL)) ? LW'(NL) : level_count_i;
    lv_nx  = lv_q + LW'(1);
    half_here = (lv_q < levels) && half_q[lv_q];
    half_next = (lv_nx < levels) && half_q[lv_nx];
    merge_lo = (held_lo_q[lv_q] < carry_lo_q) ? held_lo_q[lv_q] : carry_lo_q;
    merge_hi = (held_hi_q[lv_q] > carry_hi_q) ? held_hi_q[lv_q] : carry_hi_q;

    status_o.frame_done = completes;
    status_o.last       = out_q.last_of_run;
  end

  assign out_word_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      lo_q   <= '0;
      hi_q   <= '0;
      fin_q  <= '0;
      half_q <= '0;
      lv_q   <= '0;
      for (int i = 0; i < NL; i++) begin
        held_lo_q[i] <= '0;
        held_hi_q[i] <= '0;
        lvl_cnt_q[i] <= '0;
      end
    end else begin
      if (cmd_i.take) begin
        if (in_word_i.start_clip) begin
          half_q <= '0;
          for (int i = 0; i < NL; i++) begin
            held_lo_q[i] <= '0;
            held_hi_q[i] <= '0;
            lvl_cnt_q[i] <= '0;
          end
        end
        if (blocked) begin
          cnt_q <= cnt_e;
          lo_q  <= lo_e;
          hi_q  <= hi_e;
          fin_q <= fin_e;
        end else if (completes) begin
          cnt_q <= '0;
          lo_q  <= '0;
          hi_q  <= '0;
          fin_q <= fin_e + IW'(1);
          lv_q  <= '0;
        end else begin
          cnt_q <= cnt_e + CW'(1);
          lo_q  <= lo_n;
          hi_q  <= hi_n;
          fin_q <= fin_e;
        end
      end
      if (cmd_i.step && (lv_q < levels)) begin
        if (half_q[lv_q]) begin
          half_q[lv_q]    <= 1'b0;
          lvl_cnt_q[lv_q] <= lvl_cnt_q[lv_q] + IW'(1);
          lv_q            <= lv_nx;
        end else begin
          // Lone frame: hold it until its partner arrives.
          held_lo_q[lv_q] <= carry_lo_q;
          held_hi_q[lv_q] <= carry_hi_q;
          half_q[lv_q]    <= 1'b1;
        end
      end
    end
  end

  // Result word and the frame that climbs the cascade.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && completes) begin
      out_q.level       <= '0;
      out_q.frame_index <= fin_e;
      out_q.min_value   <= scaled_lo;
      out_q.max_value   <= scaled_hi[6:0];
      out_q.last_of_run <= !((levels != '0) && !in_word_i.start_clip && half_q[0]);
      carry_lo_q        <= scaled_lo;
      carry_hi_q        <= scaled_hi[6:0];
    end else if (cmd_i.step && half_here) begin
      out_q.level       <= lv_nx;
      out_q.frame_index <= lvl_cnt_q[lv_q];
      out_q.min_value   <= merge_lo;
      out_q.max_value   <= merge_hi;
      out_q.last_of_run <= !half_next;
      carry_lo_q        <= merge_lo;
      carry_hi_q        <= merge_hi;
    end
  end

endmodule

`default_nettype wire

// File: rtl/waveform_min_max_pyramid.sv
// A sample that closes a level-0 frame shows its first word in the cycle after it is taken.
// The merged frames of higher levels follow at one word per cycle while out_stall_i is low.
// Throughput: one sample per cycle, except that after a completed frame the input stalls while its
// words (one to thirteen) are shown; the walk up the cascade sets how many words there are.
// Reset (rst_ni low, asynchronous) clears all counters and held frames, level_count to zero
// and frame_limit to its maximum.
`default_nettype none

module waveform_min_max_pyramid (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wmmp_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output wmmp_pkg::out_word_t  out_word_o,
  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  wire  [2:0]           paddr,
  input  wire  [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [wmmp_pkg::LvlW-1:0] level_count_q;
  logic [wmmp_pkg::IdxW-1:0] frame_limit_q;
  wmmp_pkg::cmd_t            cmd;
  wmmp_pkg::status_t         status;

  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[2])
      wmmp_pkg::RegLevelCount: prdata = {28'd0, level_count_q};
      wmmp_pkg::RegFrameLimit: prdata = {12'd0, frame_limit_q};
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_count_q <= '0;
      frame_limit_q <= '1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        wmmp_pkg::RegLevelCount: level_count_q <= pwdata[wmmp_pkg::LvlW-1:0];
        wmmp_pkg::RegFrameLimit: frame_limit_q <= pwdata[wmmp_pkg::IdxW-1:0];
        default: ;
      endcase
    end
  end

  wmmp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  wmmp_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .in_word_i     (in_word_i),
    .level_count_i (level_count_q),
    .frame_limit_i (frame_limit_q),
    .status_o      (status),
    .out_word_o    (out_word_o)
  );

endmodule

`default_nettype wire

// File: rtl/wmmp_checker.sv
`default_nettype none

module wmmp_checker (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 in_stall_o,
  input wire                 out_valid_o,
  input wire                 out_stall_i,
  input wmmp_pkg::out_word_t out_word_o
);

  // A waiting result word holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // No sample is taken while a word of a run is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("sample taken during a run");

  // Every run opens with its level-0 frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (out_word_o.level == '0))
    else $error("run did not start at level zero");

  // A word that is not the last is followed at once by the next one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_word_o.last_of_run |=> out_valid_o)
    else $error("run ended early");

  // After the last word the run is over.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_word_o.last_of_run |=> !out_valid_o)
    else $error("word shown after the last of its run");

endmodule

bind waveform_min_max_pyramid wmmp_checker u_wmmp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire

// File: tb/tb_waveform_min_max_pyramid.sv
`timescale 1ns / 100ps

module tb_waveform_min_max_pyramid;

  localparam int unsigned IdleLimit   = 5000;
  localparam int unsigned TotalWords  = 430;
  localparam int unsigned SettleTicks = 20;
  localparam logic [wmmp_pkg::IdxW-1:0] NoFrameLimit = '1;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  wmmp_pkg::in_word_t   in_word_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  wmmp_pkg::out_word_t  out_word_o;
  logic                 psel        = 1'b0;
  logic                 penable     = 1'b0;
  logic                 pwrite      = 1'b0;
  logic [2:0]           paddr       = '0;
  logic [31:0]          pwdata      = '0;
  logic [31:0]          prdata;
  logic                 pready;

  waveform_min_max_pyramid dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #4 clk_i = ~clk_i;

  // Shadow copy of the pyramid state and its configuration.
  logic [wmmp_pkg::LvlW-1:0] cfg_levels      = '0;
  logic [wmmp_pkg::IdxW-1:0] cfg_frame_limit = '1;
  int unsigned               samples_taken;
  int                        frame_lo;
  int                        frame_hi;
  logic [wmmp_pkg::IdxW-1:0] finest_done;
  bit                        half_held  [wmmp_pkg::MaxLevels];
  int                        held_lo    [wmmp_pkg::MaxLevels];
  int                        held_hi    [wmmp_pkg::MaxLevels];
  logic [wmmp_pkg::IdxW-1:0] level_done [wmmp_pkg::MaxLevels];

  wmmp_pkg::out_word_t frames_expected [$];
  wmmp_pkg::in_word_t  samples_to_send [$];
  int unsigned samples_in_flight = 0;
  int unsigned samples_queued    = 0;
  int unsigned mismatches        = 0;
  int unsigned idle_cycles       = 0;

  function automatic void clear_pyramid();
    samples_taken = 0;
    frame_lo      = 0;
    frame_hi      = 0;
    finest_done   = '0;
    for (int lv = 0; lv < wmmp_pkg::MaxLevels; lv++) begin
      half_held[lv]  = 1'b0;
      held_lo[lv]    = 0;
      held_hi[lv]    = 0;
      level_done[lv] = '0;
    end
  endfunction

  // Q1.15 times 127, truncated toward zero.
  function automatic int q15_to_byte(int s);
    int mag;
    mag = (s < 0) ? -s : s;
    mag = (mag * 127) >>> 15;
    return (s < 0) ? -mag : mag;
  endfunction

  function automatic wmmp_pkg::out_word_t frame_word(int lvl,
                                                     logic [wmmp_pkg::IdxW-1:0] idx,
                                                     int mn, int mx);
    wmmp_pkg::out_word_t f;
    f.level       = wmmp_pkg::LvlW'(lvl);
    f.frame_index = idx;
    f.min_value   = 8'(mn);
    f.max_value   = 7'(mx);
    f.last_of_run = 1'b0;
    return f;
  endfunction

  task automatic predict_frames(input wmmp_pkg::in_word_t w);
    wmmp_pkg::out_word_t batch [$];
    int        s;
    int        mn;
    int        mx;
    int        lim;
    if (w.start_clip) clear_pyramid();
    if (finest_done >= cfg_frame_limit) return;
    s = int'($signed(w.sample));
    if (s < frame_lo) frame_lo = s;
    if (s > frame_hi) frame_hi = s;
    samples_taken++;
    if (samples_taken < wmmp_pkg::FrameSamples) return;
    samples_taken = 0;
    mn = q15_to_byte(frame_lo);
    mx = q15_to_byte(frame_hi);
    frame_lo = 0;
    frame_hi = 0;
    batch.push_back(frame_word(0, finest_done, mn, mx));
    finest_done = finest_done + 1'b1;
    lim = (cfg_levels > wmmp_pkg::MaxLevels) ? wmmp_pkg::MaxLevels : int'(cfg_levels);
    for (int lv = 0; lv < lim; lv++) begin
      if (!half_held[lv]) begin
        held_lo[lv]   = mn;
        held_hi[lv]   = mx;
        half_held[lv] = 1'b1;
        break;
      end
      if (held_lo[lv] < mn) mn = held_lo[lv];
      if (held_hi[lv] > mx) mx = held_hi[lv];
      half_held[lv] = 1'b0;
      batch.push_back(frame_word(lv + 1, level_done[lv], mn, mx));
      level_done[lv] = level_done[lv] + 1'b1;
    end
    batch[batch.size() - 1].last_of_run = 1'b1;
    foreach (batch[i]) frames_expected.push_back(batch[i]);
  endtask

  function automatic string show(wmmp_pkg::out_word_t w);
    return $sformatf("level %0d index %0d min %0d max %0d last %0b",
                     w.level, w.frame_index, w.min_value, w.max_value, w.last_of_run);
  endfunction

  task automatic note_mismatch(string text);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", text);
  endtask

  // Sample driver: bursts of random length separated by random gaps.
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_frames(in_word_i);
        samples_in_flight--;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (samples_to_send.size() != 0) begin
          in_word_i  <= samples_to_send.pop_front();
          in_valid_i <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: the stall density changes at random intervals.
  int unsigned stall_pct  = 0;
  int unsigned stall_span = 0;

  always @(posedge clk_i) begin
    if (stall_span == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_pct <= 0;
        1:       stall_pct <= 25;
        2:       stall_pct <= 50;
        default: stall_pct <= 85;
      endcase
      stall_span <= $urandom_range(32, 160);
    end else begin
      stall_span <= stall_span - 1;
    end
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // Frame monitor.
  always @(posedge clk_i) begin
    wmmp_pkg::out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (frames_expected.size() == 0) begin
        note_mismatch({"no word expected, got ", show(out_word_o)});
      end else begin
        want = frames_expected.pop_front();
        if (out_word_o.level !== want.level ||
            out_word_o.frame_index !== want.frame_index ||
            out_word_o.min_value !== want.min_value ||
            out_word_o.max_value !== want.max_value ||
            out_word_o.last_of_run !== want.last_of_run)
          note_mismatch({"expected ", show(want), ", got ", show(out_word_o)});
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic idx, input logic [31:0] value);
    logic [31:0] want;
    want = (idx == wmmp_pkg::RegLevelCount) ? {28'b0, value[wmmp_pkg::LvlW-1:0]}
                                            : {12'b0, value[wmmp_pkg::IdxW-1:0]};
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == wmmp_pkg::RegLevelCount) cfg_levels = value[wmmp_pkg::LvlW-1:0];
    else cfg_frame_limit = value[wmmp_pkg::IdxW-1:0];
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== want)
      note_mismatch($sformatf("register %0d reads %0h, expected %0h", idx, prdata, want));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic queue_sample(input logic [15:0] sample, input bit clip);
    wmmp_pkg::in_word_t w;
    w.sample     = sample;
    w.start_clip = clip;
    samples_to_send.push_back(w);
    samples_in_flight++;
    samples_queued++;
  endtask

  function automatic logic [15:0] pick_sample(int style);
    case (style)
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(0, 32767));
      2:       return 16'(-int'($urandom_range(1, 32768)));
      default: return 16'(int'($urandom_range(0, 1023)) - 512);
    endcase
  endfunction

  // Each frame gets its own amplitude profile; noise_pm is the per-mille
  // chance of a stray clip restart in the middle of the stream.
  task automatic queue_frames(input int frames, input bit clip_first, input int noise_pm);
    int style;
    for (int f = 0; f < frames; f++) begin
      style = $urandom_range(0, 3);
      for (int k = 0; k < wmmp_pkg::FrameSamples; k++)
        queue_sample(pick_sample(style),
                     (clip_first && f == 0 && k == 0) || ($urandom_range(0, 999) < noise_pm));
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (samples_in_flight != 0 || frames_expected.size() != 0);
    repeat (SettleTicks) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [15:0] extremes [16];
    int unsigned levels;
    int unsigned limit;
    extremes = '{16'h8000, 16'h7fff, 16'hffff, 16'h0001, 16'h0000, 16'h0103, 16'hfefd,
                 16'h0102, 16'hfefe, 16'h5555, 16'haaaa, 16'h00ff, 16'hff00, 16'h4000,
                 16'hc000, 16'h0000};
    clear_pyramid();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration: level zero only, no frame limit.
    foreach (extremes[i]) queue_sample(extremes[i], 1'b0);
    wait_idle();

    // Full pyramid; a clip restart in the middle of a frame drops the partial
    // frame and every lone frame held so far.
    write_reg(wmmp_pkg::RegLevelCount, wmmp_pkg::MaxLevels);
    write_reg(wmmp_pkg::RegFrameLimit, NoFrameLimit);
    queue_frames(4, 1'b1, 0);
    for (int k = 0; k < 7; k++) queue_sample(pick_sample(0), 1'b0);
    queue_sample(16'h8000, 1'b1);
    for (int k = 1; k < wmmp_pkg::FrameSamples; k++) queue_sample(pick_sample(1), 1'b0);
    queue_frames(1, 1'b0, 0);
    wait_idle();

    // Fewer levels mid-clip: frames held above stay put, then come back.
    write_reg(wmmp_pkg::RegLevelCount, 1);
    queue_frames(2, 1'b0, 0);
    wait_idle();
    write_reg(wmmp_pkg::RegLevelCount, 15);
    queue_frames(2, 1'b0, 0);
    wait_idle();

    // Frame limit: zero lets nothing through; a clip restart reopens it.
    write_reg(wmmp_pkg::RegFrameLimit, 0);
    queue_frames(1, 1'b0, 0);
    wait_idle();
    write_reg(wmmp_pkg::RegFrameLimit, 2);
    queue_frames(3, 1'b1, 0);
    queue_frames(1, 1'b1, 0);
    wait_idle();

    while (samples_queued < TotalWords) begin
      case ($urandom_range(0, 4))
        0:       levels = 0;
        1:       levels = 15;
        2:       levels = wmmp_pkg::MaxLevels;
        default: levels = $urandom_range(1, 15);
      endcase
      limit = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : NoFrameLimit;
      write_reg(wmmp_pkg::RegLevelCount, levels);
      write_reg(wmmp_pkg::RegFrameLimit, limit);
      queue_frames($urandom_range(2, 8), $urandom_range(0, 2) != 0, 15);
      if ($urandom_range(0, 2) == 0)
        for (int k = $urandom_range(1, 15); k > 0; k--) queue_sample(pick_sample(0), 1'b0);
      wait_idle();
    end

    if (mismatches == 0 && frames_expected.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/wmmp_pkg.sv
rtl/wmmp_ctrl.sv
rtl/wmmp_datapath.sv
rtl/waveform_min_max_pyramid.sv
rtl/wmmp_checker.sv
tb/tb_waveform_min_max_pyramid.sv
